/* hdl/tahr_pkg.sv */
package tahr_pkg;

  localparam int NUM_CHANNELS        = 5;
  localparam int SAMPLES_PER_AVERAGE = 15;
  localparam int ADC_BITS            = 10;

  localparam int TEMP_W     = 17;
  localparam int LIMIT_W    = 4;
  localparam int CH_IDX_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam int ROM_DEPTH = 2 ** ADC_BITS;
  localparam int ADC_FULL  = ROM_DEPTH - 1;
  localparam int SUM_W     = $clog2(SAMPLES_PER_AVERAGE * ADC_FULL + 1);
  localparam int RND_W     = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;

  // divide by the round count as multiply by a rounded-up reciprocal
  localparam int DIV_SH  = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
  localparam int DIV_K   = ((2 ** DIV_SH) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
  localparam int DIV_K_W = DIV_SH + 1;
  localparam int PROD_W  = SUM_W + DIV_K_W;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [ADC_BITS-1:0]      sample_t;
  typedef logic [SUM_W-1:0]         sum_t;
  typedef logic [ADC_BITS-1:0]      rom_addr_t;
  typedef logic [LIMIT_W-1:0]       limit_t;
  typedef logic [CH_IDX_W-1:0]      ch_idx_t;

  localparam temp_t   TEMP_MIN      = -17'sd27315;
  localparam temp_t   TEMP_MAX      = 17'sd35000;
  localparam temp_t   ON_THR_RST    = 17'sd2800;
  localparam temp_t   OFF_THR_RST   = 17'sd3000;
  localparam limit_t  LIMIT_RST     = 4'd5;
  localparam ch_idx_t MON_RST       = 3'd3;
  localparam limit_t  CNT_MAX       = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ON_THR  = 2'd0,
    CFG_OFF_THR = 2'd1,
    CFG_LIMIT   = 2'd2,
    CFG_MON     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    temp_t   on_thr;
    temp_t   off_thr;
    limit_t  limit;
    ch_idx_t mon;
  } relay_cfg_t;

  typedef struct packed {
    logic on;
    logic changed;
  } relay_res_t;

  typedef struct packed {
    logic      we;
    rom_addr_t addr;
    temp_t     data;
  } rom_wr_t;

  // ---- table generation, evaluated at elaboration ----

  localparam logic [63:0] SERIES_OHM  = 64'd10000;
  localparam logic [63:0] NOMINAL_OHM = 64'd9700;
  localparam logic [63:0] LN2_Q30     = 64'd744261118;
  localparam logic [63:0] T0_HUND     = 64'd29815;
  localparam logic [63:0] BASE_TERM   = 64'd395000;
  localparam logic [63:0] NUMER_TERM  = 64'd11776925000;
  localparam logic [63:0] Q_CLAMP     = 64'd1000000;

  function automatic logic [63:0] log2_q28(input logic [63:0] x);
    logic [63:0] y;
    logic [63:0] r;
    int          n;
    n = 0;
    y = '0;
    r = '0;
    if (x != 0) begin
      for (int k = 1; k < 63; k++) begin
        if ((x >> k) != 0) n = k;
      end
      if (n <= 30) y = x << (30 - n);
      else         y = x >> (n - 30);
      r = 64'(n) << 28;
      for (int i = 27; i >= 0; i--) begin
        y = (y * y) >> 30;
        if (y >= (64'd2 << 30)) begin
          y    = y >> 1;
          r[i] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // restoring long division
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic temp_t temp_of_code(input int a);
    logic [63:0]        lp;
    logic [63:0]        lq;
    logic [63:0]        mag;
    logic [63:0]        lmag;
    logic [63:0]        t;
    logic [63:0]        d;
    logic [63:0]        q;
    logic               neg;
    logic signed [63:0] res;
    if (a == 0 || a >= ADC_FULL) return TEMP_MIN;
    lp = log2_q28(SERIES_OHM * 64'(a));
    lq = log2_q28(NOMINAL_OHM * 64'(ADC_FULL - a));
    if (lp >= lq) begin
      mag = lp - lq;
      neg = 1'b0;
    end else begin
      mag = lq - lp;
      neg = 1'b1;
    end
    lmag = (mag * LN2_Q30) >> 30;
    t    = T0_HUND * lmag;
    d    = BASE_TERM << 28;
    if (neg) begin
      if (t >= d) return TEMP_MAX;
      d = d - t;
    end else begin
      d = d + t;
    end
    q = udiv64((NUMER_TERM << 28) + (d >> 1), d);
    if (q > Q_CLAMP) q = Q_CLAMP;
    res = $signed(q) + 64'(signed'(TEMP_MIN));
    if (res > 64'(signed'(TEMP_MAX))) res = 64'(signed'(TEMP_MAX));
    if (res < 64'(signed'(TEMP_MIN))) res = 64'(signed'(TEMP_MIN));
    return temp_t'(res[TEMP_W-1:0]);
  endfunction

  typedef temp_t temp_rom_t [ROM_DEPTH];

  function automatic temp_rom_t build_temp_rom();
    temp_rom_t rom;
    for (int a = 0; a < ROM_DEPTH; a++) begin
      rom[a] = temp_of_code(a);
    end
    return rom;
  endfunction

  localparam temp_rom_t TEMP_ROM = build_temp_rom();

endpackage

/* hdl/tahr_if.sv */
interface tahr_in_if;
  import tahr_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_ch0;
  sample_t sample_ch1;
  sample_t sample_ch2;
  sample_t sample_ch3;
  sample_t sample_ch4;

  modport source (
    output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4,
    input  ready
  );
  modport sink (
    input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4,
    output ready
  );
endinterface

interface tahr_out_if;
  import tahr_pkg::*;

  logic  valid;
  logic  ready;
  temp_t temp_ch0;
  temp_t temp_ch1;
  temp_t temp_ch2;
  temp_t temp_ch3;
  temp_t temp_ch4;
  logic  relay_on;
  logic  relay_changed;

  modport source (
    output valid, temp_ch0, temp_ch1, temp_ch2, temp_ch3, temp_ch4,
           relay_on, relay_changed,
    input  ready
  );
  modport sink (
    input  valid, temp_ch0, temp_ch1, temp_ch2, temp_ch3, temp_ch4,
           relay_on, relay_changed,
    output ready
  );
endinterface

/* hdl/tahr_ram.sv */
module tahr_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem[raddr_i];
  end

endmodule

/* hdl/tahr_lane.sv */
module tahr_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tahr_pkg::sample_t sample_i,
  input  logic              acc_en_i,
  input  logic              last_i,
  input  logic              adv_i,
  input  tahr_pkg::rom_wr_t rom_wr_i,
  output tahr_pkg::temp_t   temp_o
);
  import tahr_pkg::*;

  sum_t              sum_q;
  sum_t              sum_d;
  sum_t              fin_sum_q;
  logic [PROD_W-1:0] prod;
  rom_addr_t         avg;
  logic [TEMP_W-1:0] rdata;

  assign sum_d = sum_q + SUM_W'(sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (acc_en_i) begin
      sum_q <= last_i ? '0 : sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_en_i && last_i) fin_sum_q <= sum_d;
  end

  // truncated average by reciprocal multiply
  assign prod = PROD_W'(fin_sum_q) * PROD_W'(DIV_K);
  assign avg  = prod[DIV_SH +: ADC_BITS];

  tahr_ram #(
    .WIDTH (TEMP_W),
    .DEPTH (ROM_DEPTH)
  ) u_rom (
    .clk_i   (clk_i),
    .we_i    (rom_wr_i.we),
    .waddr_i (rom_wr_i.addr),
    .wdata_i (rom_wr_i.data),
    .re_i    (adv_i),
    .raddr_i (avg),
    .rdata_o (rdata)
  );

  assign temp_o = temp_t'(rdata);

endmodule

/* hdl/tahr_relay.sv */
module tahr_relay (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 upd_i,
  input  tahr_pkg::temp_t      temps_i [tahr_pkg::NUM_CHANNELS],
  input  tahr_pkg::relay_cfg_t cfg_i,
  output tahr_pkg::relay_res_t res_o
);
  import tahr_pkg::*;

  logic   relay_q;
  logic   relay_d;
  limit_t cnt_q;
  limit_t cnt_d;
  limit_t cnt_inc;
  temp_t  sel;
  logic   found;
  logic   qual;
  logic   toggle;

  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int j = 0; j < NUM_CHANNELS; j++) begin
      if (cfg_i.mon == CH_IDX_W'(j)) begin
        sel   = temps_i[j];
        found = 1'b1;
      end
    end
    qual    = found && (relay_q ? (sel > cfg_i.off_thr) : (sel < cfg_i.on_thr));
    cnt_inc = (qual && cnt_q != CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
    toggle  = cnt_inc > cfg_i.limit;
    cnt_d   = toggle ? '0 : cnt_inc;
    relay_d = relay_q ^ toggle;
  end

  assign res_o.on      = relay_d;
  assign res_o.changed = toggle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_q <= 1'b0;
      cnt_q   <= '0;
    end else if (upd_i) begin
      relay_q <= relay_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* hdl/thermistor_average_hysteresis_relay_unit.sv */
// Thermistor averaging and hysteresis relay. Each word on sample_i is one round
// of five raw ADC codes; the unit takes one word per clock unless result_o
// stalls or the table is loading. Every fifteenth round closes an average: each
// channel's truncated mean is looked up in a beta-formula temperature table
// (hundredths of a degree C, -27315 for the rail codes) and the monitored channel
// steps the hysteresis relay. One word then appears on result_o after the closing
// round passes the closed-sum stage, the table read and the output register;
// other rounds give no word. Each lane has one table RAM read port. After reset
// the unit loads the table into the lane RAMs; sample_i.ready stays low until
// that is done, while configuration writes are taken throughout. Write the
// registers only while no averaged round is still on its way out.
module thermistor_average_hysteresis_relay_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tahr_in_if.sink                          sample_i,
  tahr_out_if.source                       result_o,
  input  logic                             cfg_we_i,
  input  logic [tahr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tahr_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import tahr_pkg::*;

  // configuration registers
  relay_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_thr  <= ON_THR_RST;
      cfg_q.off_thr <= OFF_THR_RST;
      cfg_q.limit   <= LIMIT_RST;
      cfg_q.mon     <= MON_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ON_THR:  cfg_q.on_thr  <= temp_t'(cfg_wdata_i[TEMP_W-1:0]);
        CFG_OFF_THR: cfg_q.off_thr <= temp_t'(cfg_wdata_i[TEMP_W-1:0]);
        CFG_LIMIT:   cfg_q.limit   <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_MON:     cfg_q.mon     <= cfg_wdata_i[CH_IDX_W-1:0];
        default:     cfg_q         <= cfg_q;
      endcase
    end
  end

  // table load after reset, one entry per cycle into every lane
  logic      filling_q;
  rom_addr_t fill_addr_q;
  rom_wr_t   rom_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filling_q   <= 1'b1;
      fill_addr_q <= '0;
    end else if (filling_q) begin
      fill_addr_q <= fill_addr_q + 1'b1;
      if (fill_addr_q == '1) filling_q <= 1'b0;
    end
  end

  assign rom_wr.we   = filling_q;
  assign rom_wr.addr = fill_addr_q;
  assign rom_wr.data = TEMP_ROM[fill_addr_q];

  // pipeline control: the whole pipe moves when the output register can take a word
  logic adv;
  logic accept;
  logic last_round;
  logic s1_valid_q;
  logic s2_valid_q;
  logic out_valid_q;

  logic [RND_W-1:0] rnd_q;

  assign adv            = !out_valid_q || result_o.ready;
  assign sample_i.ready = adv && !filling_q;
  assign accept         = sample_i.valid && sample_i.ready;
  assign last_round     = rnd_q == RND_W'(SAMPLES_PER_AVERAGE - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
    end else if (accept) begin
      rnd_q <= last_round ? '0 : rnd_q + 1'b1;
    end
  end

  // stage 1 holds closed sums, stage 2 is the table read, then the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= accept && last_round;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // lanes, one per channel
  sample_t samples [NUM_CHANNELS];
  temp_t   temps   [NUM_CHANNELS];

  assign samples[0] = sample_i.sample_ch0;
  assign samples[1] = sample_i.sample_ch1;
  assign samples[2] = sample_i.sample_ch2;
  assign samples[3] = sample_i.sample_ch3;
  assign samples[4] = sample_i.sample_ch4;

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
    tahr_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .sample_i (samples[g]),
      .acc_en_i (accept),
      .last_i   (last_round),
      .adv_i    (adv),
      .rom_wr_i (rom_wr),
      .temp_o   (temps[g])
    );
  end

  // merge: relay update from the monitored lane
  logic       upd;
  relay_res_t relay_res;

  assign upd = adv && s2_valid_q;

  tahr_relay u_relay (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .temps_i (temps),
    .cfg_i   (cfg_q),
    .res_o   (relay_res)
  );

  // output register
  temp_t      temp_q [NUM_CHANNELS];
  relay_res_t res_q;

  always_ff @(posedge clk_i) begin
    if (upd) begin
      temp_q <= temps;
      res_q  <= relay_res;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.temp_ch0      = temp_q[0];
  assign result_o.temp_ch1      = temp_q[1];
  assign result_o.temp_ch2      = temp_q[2];
  assign result_o.temp_ch3      = temp_q[3];
  assign result_o.temp_ch4      = temp_q[4];
  assign result_o.relay_on      = res_q.on;
  assign result_o.relay_changed = res_q.changed;

endmodule

/* hdl/tahr_checker.sv */
module tahr_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  tahr_pkg::temp_t temp_ch0_i,
  input  tahr_pkg::temp_t temp_ch1_i,
  input  tahr_pkg::temp_t temp_ch2_i,
  input  tahr_pkg::temp_t temp_ch3_i,
  input  tahr_pkg::temp_t temp_ch4_i,
  input  logic            relay_on_i,
  input  logic            relay_changed_i
);
  import tahr_pkg::*;

  logic             in_acc;
  logic             out_acc;
  logic             closes;
  logic [RND_W-1:0] rnd_q;
  logic [2:0]       pend_q;
  logic             last_relay_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign closes  = in_acc && (rnd_q == RND_W'(SAMPLES_PER_AVERAGE - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q        <= '0;
      pend_q       <= '0;
      last_relay_q <= 1'b0;
    end else begin
      if (in_acc) rnd_q <= closes ? '0 : rnd_q + 1'b1;
      pend_q <= pend_q + 3'(closes) - 3'(out_acc);
      if (out_acc) last_relay_q <= relay_on_i;
    end
  end

  function automatic logic in_range(input temp_t t);
    return (t >= TEMP_MIN) && (t <= TEMP_MAX);
  endfunction

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 3'd0)
    else $error("result word without a closed average");

  a_relay_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> relay_on_i == (last_relay_q ^ relay_changed_i))
    else $error("relay state disagrees with change flag");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> in_range(temp_ch0_i) && in_range(temp_ch1_i) &&
                    in_range(temp_ch2_i) && in_range(temp_ch3_i) &&
                    in_range(temp_ch4_i))
    else $error("temperature out of range");

endmodule

bind thermistor_average_hysteresis_relay_unit tahr_checker u_tahr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (sample_i.valid),
  .in_ready_i      (sample_i.ready),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .temp_ch0_i      (result_o.temp_ch0),
  .temp_ch1_i      (result_o.temp_ch1),
  .temp_ch2_i      (result_o.temp_ch2),
  .temp_ch3_i      (result_o.temp_ch3),
  .temp_ch4_i      (result_o.temp_ch4),
  .relay_on_i      (result_o.relay_on),
  .relay_changed_i (result_o.relay_changed)
);
